// ----- rtl/ajst_pkg.sv -----
// ----------------------------------------------------------------------------
// Accelerometer jerk and speed tracker package
// Shared types, register indexes and reset values for the tracker block.
// ----------------------------------------------------------------------------
package ajst_pkg;

    localparam int AXIS_W    = 8;
    localparam int MS_W      = 16;
    localparam int THR_W     = 8;
    localparam int GAIN_W    = 16;
    localparam int SPEED_W   = 32;
    localparam int MAG_W     = 16;
    localparam int SUMSQ_W   = 16;
    localparam int RAD_W     = 32;
    localparam int REM_W     = 20;
    localparam int MUL_A_W   = 25;
    localparam int MUL_B_W   = 17;
    localparam int PROD_W    = MUL_A_W + MUL_B_W;
    localparam int SUM_W     = PROD_W + 1;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 32;
    localparam int IN_DATA_W = 40;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_JERK_THRESHOLD    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_SPEED_CUTOFF  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_ALARM_LEVEL = 8'd3;

    localparam logic [THR_W-1:0]   RST_JERK_THRESHOLD    = 8'd69;
    localparam logic [GAIN_W-1:0]  RST_SPEED_GAIN        = 16'd10665;
    localparam logic [SPEED_W-1:0] RST_LOW_SPEED_CUTOFF  = 32'd1677722;
    localparam logic [SPEED_W-1:0] RST_SPEED_ALARM_LEVEL = 32'd167772160;

    localparam logic [3:0] ROOT_LAST_STEP = 4'd15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_XX,
        ST_MUL_YY,
        ST_MUL_ZZ,
        ST_MUL_XG,
        ST_MUL_XGT,
        ST_SPEED,
        ST_ROOT,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        MUL_XX,
        MUL_YY,
        MUL_ZZ,
        MUL_XG,
        MUL_XGT
    } t_mul_sel;

    typedef struct packed {
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     sum_clr;
        logic     sum_add;
        logic     root_init;
        logic     root_step;
        logic     speed_upd;
        logic     finish;
    } t_ctrl;

endpackage

// ----- rtl/accel_jerk_and_speed_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Accelerometer jerk and speed tracker
// Computes the Q8.8 vector magnitude, a sudden-motion flag and an integrated
// X-axis speed with saturation, cutoff and over-speed flag.
// ----------------------------------------------------------------------------
// Input items arrive on the s_axis channel: three signed axis samples and the
// milliseconds since the previous sample. Each item yields one result item on
// the m_axis channel with the speed and magnitude in tdata and the two flags
// in tuser. Registers are written on the cfg channel, which is always ready;
// they should be written only while no item is in flight.
// An accepted item passes through one shared multiplier (three squares, then
// gain and time products), the speed sum, a one-bit-per-cycle square root
// and the final compares. The result becomes valid and s_axis_tready returns
// at the same time, so no new item is taken while one is in flight.
// The result sits in an output register; if the receiver stalls, the next
// item is still taken and runs to its final step, where it waits until the
// previous result is taken. Reset restores the register defaults and clears
// the stored speed and previous magnitude.
// ----------------------------------------------------------------------------
module accel_jerk_and_speed_tracker_unit
    import ajst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // accel_x [7:0], accel_y [15:8], accel_z [23:16], elapsed_ms [39:24]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // speed [31:0], magnitude [47:32]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // sudden_motion [0], over_speed [1]
    output logic [OUT_USER_W-1:0] m_axis_tuser,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DAT_W-1:0]  i_cfg_data
);

    t_state r_state, n_state;
    t_ctrl  ctrl;

    logic [THR_W-1:0]   r_jerk_threshold;
    logic [GAIN_W-1:0]  r_speed_gain;
    logic [SPEED_W-1:0] r_low_speed_cutoff;
    logic [SPEED_W-1:0] r_speed_alarm_level;

    logic [MAG_W-1:0]   r_last_mag;
    logic [SPEED_W-1:0] r_speed;

    logic signed [AXIS_W-1:0] r_x, r_y, r_z;
    logic [MS_W-1:0]          r_ms;
    logic signed [PROD_W-1:0] r_prod;
    logic [SUMSQ_W-1:0]       r_sumsq;
    logic [RAD_W-1:0]         r_rad;
    logic [REM_W-1:0]         r_rem;
    logic [MAG_W-1:0]         r_root;
    logic [3:0]               r_cnt;
    logic [SPEED_W-1:0]       r_sat;

    logic                  r_out_valid;
    logic [SPEED_W-1:0]    r_out_speed;
    logic [MAG_W-1:0]      r_out_mag;
    logic                  r_out_sudden;
    logic                  r_out_over;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [SUM_W-1:0]   speed_sum;
    logic [SPEED_W-1:0]        speed_sat;
    logic [REM_W-1:0]          rem_sh;
    logic [REM_W-1:0]          trial;
    logic                      trial_ok;
    logic [MAG_W-1:0]          mag_diff;
    logic                      sudden;
    logic                      above_cutoff;
    logic [SPEED_W-1:0]        speed_new;
    logic                      out_free;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_mag, r_out_speed};
    assign m_axis_tuser  = {r_out_over, r_out_sudden};

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:    if (s_axis_tvalid) n_state = ST_MUL_XX;
            ST_MUL_XX:  n_state = ST_MUL_YY;
            ST_MUL_YY:  n_state = ST_MUL_ZZ;
            ST_MUL_ZZ:  n_state = ST_MUL_XG;
            ST_MUL_XG:  n_state = ST_MUL_XGT;
            ST_MUL_XGT: n_state = ST_SPEED;
            ST_SPEED:   n_state = ST_ROOT;
            ST_ROOT:    if (r_cnt == '0) n_state = ST_FINISH;
            ST_FINISH:  if (out_free) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl          = '0;
        ctrl.mul_sel  = MUL_XX;
        s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE:    s_axis_tready = 1'b1;
            ST_MUL_XX: begin
                ctrl.mul_en  = 1'b1;
                ctrl.sum_clr = 1'b1;
            end
            ST_MUL_YY: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_YY;
                ctrl.sum_add = 1'b1;
            end
            ST_MUL_ZZ: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_ZZ;
                ctrl.sum_add = 1'b1;
            end
            ST_MUL_XG: begin
                ctrl.mul_en  = 1'b1;
                ctrl.mul_sel = MUL_XG;
                ctrl.sum_add = 1'b1;
            end
            ST_MUL_XGT: begin
                ctrl.mul_en    = 1'b1;
                ctrl.mul_sel   = MUL_XGT;
                ctrl.root_init = 1'b1;
            end
            ST_SPEED:   ctrl.speed_upd = 1'b1;
            ST_ROOT:    ctrl.root_step = 1'b1;
            ST_FINISH:  ctrl.finish = out_free;
            default:    ctrl = '0;
        endcase
    end

    // Shared multiplier.
    always_comb begin
        unique case (ctrl.mul_sel)
            MUL_XX: begin
                mul_a = MUL_A_W'(r_x);
                mul_b = MUL_B_W'(r_x);
            end
            MUL_YY: begin
                mul_a = MUL_A_W'(r_y);
                mul_b = MUL_B_W'(r_y);
            end
            MUL_ZZ: begin
                mul_a = MUL_A_W'(r_z);
                mul_b = MUL_B_W'(r_z);
            end
            MUL_XG: begin
                mul_a = MUL_A_W'(r_x);
                mul_b = $signed({1'b0, r_speed_gain});
            end
            MUL_XGT: begin
                mul_a = r_prod[MUL_A_W-1:0];
                mul_b = $signed({1'b0, r_ms});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    assign speed_sum = $signed({{(SUM_W-SPEED_W){1'b0}}, r_speed}) + SUM_W'(r_prod);

    always_comb begin
        if (speed_sum[SUM_W-1]) begin
            speed_sat = '0;
        end else if (|speed_sum[SUM_W-2:SPEED_W]) begin
            speed_sat = '1;
        end else begin
            speed_sat = speed_sum[SPEED_W-1:0];
        end
    end

    assign rem_sh   = {r_rem[REM_W-3:0], r_rad[RAD_W-1 -: 2]};
    assign trial    = {{(REM_W-MAG_W-2){1'b0}}, r_root, 2'b01};
    assign trial_ok = rem_sh >= trial;

    assign mag_diff     = (r_root > r_last_mag) ? (r_root - r_last_mag) : (r_last_mag - r_root);
    assign sudden       = mag_diff > {r_jerk_threshold, 8'h00};
    assign above_cutoff = r_sat >= r_low_speed_cutoff;
    assign speed_new    = above_cutoff ? r_sat : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state             <= ST_IDLE;
            r_jerk_threshold    <= RST_JERK_THRESHOLD;
            r_speed_gain        <= RST_SPEED_GAIN;
            r_low_speed_cutoff  <= RST_LOW_SPEED_CUTOFF;
            r_speed_alarm_level <= RST_SPEED_ALARM_LEVEL;
            r_last_mag          <= '0;
            r_speed             <= '0;
            r_out_valid         <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_JERK_THRESHOLD:    r_jerk_threshold    <= i_cfg_data[THR_W-1:0];
                    CFG_SPEED_GAIN:        r_speed_gain        <= i_cfg_data[GAIN_W-1:0];
                    CFG_LOW_SPEED_CUTOFF:  r_low_speed_cutoff  <= i_cfg_data[SPEED_W-1:0];
                    CFG_SPEED_ALARM_LEVEL: r_speed_alarm_level <= i_cfg_data[SPEED_W-1:0];
                    default:               r_jerk_threshold    <= r_jerk_threshold;
                endcase
            end
            if (ctrl.finish) begin
                r_out_valid <= 1'b1;
                r_last_mag  <= r_root;
                r_speed     <= speed_new;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_x  <= s_axis_tdata[7:0];
            r_y  <= s_axis_tdata[15:8];
            r_z  <= s_axis_tdata[23:16];
            r_ms <= s_axis_tdata[39:24];
        end
        if (ctrl.mul_en) begin
            r_prod <= mul_p;
        end
        if (ctrl.sum_clr) begin
            r_sumsq <= '0;
        end else if (ctrl.sum_add) begin
            r_sumsq <= r_sumsq + r_prod[SUMSQ_W-1:0];
        end
        if (ctrl.speed_upd) begin
            r_sat <= speed_sat;
        end
        if (ctrl.root_init) begin
            r_rad  <= {r_sumsq, 16'h0000};
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= ROOT_LAST_STEP;
        end else if (ctrl.root_step) begin
            r_rad <= {r_rad[RAD_W-3:0], 2'b00};
            r_cnt <= r_cnt - 4'd1;
            if (trial_ok) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[MAG_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[MAG_W-2:0], 1'b0};
            end
        end
        if (ctrl.finish) begin
            r_out_speed  <= speed_new;
            r_out_mag    <= r_root;
            r_out_sudden <= sudden;
            r_out_over   <= above_cutoff && (r_sat > r_speed_alarm_level);
        end
    end

endmodule

// ----- rtl/ajst_checker.sv -----
// ----------------------------------------------------------------------------
// Accelerometer jerk and speed tracker checker
// Port-level assertions on the tracker, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ajst_checker
    import ajst_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [OUT_USER_W-1:0] m_axis_tuser
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in flight");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // An over-speed flag can only come with a nonzero speed.
    a_over_speed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata[31:0] != 32'd0)
        else $error("over-speed flag with zero speed");

    // The magnitude of three 8-bit axes stays below sqrt(3) * 128 in Q8.8.
    a_magnitude_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[47:32] <= 16'd56755)
        else $error("magnitude out of range");

endmodule

bind accel_jerk_and_speed_tracker_unit ajst_checker u_ajst_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- verif/tb_accel_jerk_and_speed_tracker_unit.sv -----
// ----------------------------------------------------------------------------
// Testbench for the accelerometer jerk and speed tracker
// Drives three-axis samples through the stream input, predicts every result
// with a cycle-free model of the magnitude, jerk flag and integrated speed,
// and checks each output item field by field. Registers are rewritten
// between phases, including their extremes. Both sides idle at random, and
// the receiver holds off once for a long stretch so that the input stalls.
// ----------------------------------------------------------------------------
module tb_accel_jerk_and_speed_tracker_unit;
    import ajst_pkg::*;

    localparam int     CYCLE_LIMIT   = 300000;
    localparam int     SETTLE_CYCLES = 30;
    localparam int     HOLD_AT       = 300;
    localparam int     HOLD_CYCLES   = 400;
    localparam longint SPEED_MAX     = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic [MS_W-1:0]          elapsed_ms;
        logic signed [AXIS_W-1:0] accel_z;
        logic signed [AXIS_W-1:0] accel_y;
        logic signed [AXIS_W-1:0] accel_x;
    } t_motion_sample;

    typedef struct packed {
        logic               sudden_motion;
        logic               over_speed;
        logic [SPEED_W-1:0] speed_est;
        logic [MAG_W-1:0]   magnitude;
    } t_tracker_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [OUT_USER_W-1:0] m_axis_tuser;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_data = '0;

    t_motion_sample  sample_q[$];
    t_tracker_result expected_q[$];

    logic [THR_W-1:0]   jerk_thr;
    logic [GAIN_W-1:0]  gain_per_ms;
    logic [SPEED_W-1:0] speed_floor;
    logic [SPEED_W-1:0] alarm_speed;
    logic [MAG_W-1:0]   model_last_mag;
    logic [SPEED_W-1:0] tracked_speed;

    int   error_count = 0;
    int   result_count = 0;
    int   accepted_count = 0;
    int   cycle_count = 0;
    int   gap_left = 0;
    int   stall_left = 0;
    int   hold_left = 0;
    logic hold_done = 1'b0;
    logic quiet_run = 1'b0;

    int                       run_left = 0;
    int                       run_kind = 0;
    logic signed [AXIS_W-1:0] prev_y = '0;
    logic signed [AXIS_W-1:0] prev_z = '0;

    accel_jerk_and_speed_tracker_unit uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [MAG_W-1:0] root_q8_8(input logic [31:0] v);
        logic [MAG_W-1:0] r;
        logic [MAG_W-1:0] t;
        r = '0;
        for (int b = MAG_W - 1; b >= 0; b--) begin
            t = r | (MAG_W'(1) << b);
            if (longint'(t) * longint'(t) <= longint'(v)) begin
                r = t;
            end
        end
        return r;
    endfunction

    function automatic t_tracker_result predict_tracker(input t_motion_sample s);
        t_tracker_result  res;
        int               xi;
        int               yi;
        int               zi;
        logic [31:0]      sumsq;
        logic [MAG_W-1:0] mag;
        logic [MAG_W-1:0] diff;
        longint           acc;
        xi = s.accel_x;
        yi = s.accel_y;
        zi = s.accel_z;
        sumsq = 32'(xi * xi + yi * yi + zi * zi);
        mag = root_q8_8(sumsq << 16);
        diff = (mag > model_last_mag) ? mag - model_last_mag : model_last_mag - mag;
        res.sudden_motion = diff > {jerk_thr, 8'h00};
        model_last_mag = mag;
        acc = longint'(tracked_speed) + longint'(xi) * longint'(gain_per_ms)
              * longint'(s.elapsed_ms);
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > SPEED_MAX) begin
            acc = SPEED_MAX;
        end
        tracked_speed = SPEED_W'(acc);
        if (tracked_speed < speed_floor) begin
            tracked_speed = '0;
        end
        res.over_speed = tracked_speed > alarm_speed;
        res.speed_est = tracked_speed;
        res.magnitude = mag;
        return res;
    endfunction

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH result %0d %s: got 0x%0h, want 0x%0h",
                 result_count, field, got, want);
        error_count++;
    endtask

    // Sample driver.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (gap_left != 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (!quiet_run && $urandom_range(0, 4) == 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= $urandom_range(0, 2);
            end else if (sample_q.size() != 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= sample_q.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver with short random stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (hold_left != 0) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left != 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Long receiver hold-off so the block backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && accepted_count == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: tracks register writes, predicts on accepted samples and checks results.
    always @(posedge i_clk) begin
        t_tracker_result want;
        if (!i_rst_n) begin
            jerk_thr = RST_JERK_THRESHOLD;
            gain_per_ms = RST_SPEED_GAIN;
            speed_floor = RST_LOW_SPEED_CUTOFF;
            alarm_speed = RST_SPEED_ALARM_LEVEL;
            model_last_mag = '0;
            tracked_speed = '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_JERK_THRESHOLD:    jerk_thr = i_cfg_data[THR_W-1:0];
                    CFG_SPEED_GAIN:        gain_per_ms = i_cfg_data[GAIN_W-1:0];
                    CFG_LOW_SPEED_CUTOFF:  speed_floor = i_cfg_data;
                    CFG_SPEED_ALARM_LEVEL: alarm_speed = i_cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                expected_q.push_back(predict_tracker(t_motion_sample'(s_axis_tdata)));
                accepted_count <= accepted_count + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
                end else begin
                    want = expected_q.pop_front();
                    if (m_axis_tuser[0] !== want.sudden_motion) begin
                        report_mismatch("sudden_motion", 32'(m_axis_tuser[0]),
                                        32'(want.sudden_motion));
                    end
                    if (m_axis_tuser[1] !== want.over_speed) begin
                        report_mismatch("over_speed", 32'(m_axis_tuser[1]),
                                        32'(want.over_speed));
                    end
                    if (m_axis_tdata[SPEED_W-1:0] !== want.speed_est) begin
                        report_mismatch("speed", m_axis_tdata[SPEED_W-1:0],
                                        want.speed_est);
                    end
                    if (m_axis_tdata[SPEED_W +: MAG_W] !== want.magnitude) begin
                        report_mismatch("magnitude", 32'(m_axis_tdata[SPEED_W +: MAG_W]),
                                        32'(want.magnitude));
                    end
                end
                result_count++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_all_regs(input logic [THR_W-1:0] thr, input logic [GAIN_W-1:0] gain,
                                  input logic [SPEED_W-1:0] cutoff,
                                  input logic [SPEED_W-1:0] alarm);
        write_reg(CFG_JERK_THRESHOLD, CFG_DAT_W'(thr));
        write_reg(CFG_SPEED_GAIN, CFG_DAT_W'(gain));
        write_reg(CFG_LOW_SPEED_CUTOFF, cutoff);
        write_reg(CFG_SPEED_ALARM_LEVEL, alarm);
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (sample_q.size() != 0 || s_axis_tvalid || expected_q.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic push_sample(input int x, input int y, input int z, input int ms);
        t_motion_sample s;
        s.accel_x = AXIS_W'(x);
        s.accel_y = AXIS_W'(y);
        s.accel_z = AXIS_W'(z);
        s.elapsed_ms = MS_W'(ms);
        sample_q.push_back(s);
    endtask

    // Runs of samples: pure noise, or steady pushes forward or backward with
    // small motion on the other axes, so the speed climbs and falls gradually.
    task automatic push_random(input int n);
        int x;
        int ms;
        for (int i = 0; i < n; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(4, 24);
                run_kind = $urandom_range(0, 3);
            end
            run_left--;
            case (run_kind)
                1: x = $urandom_range(0, 40);
                2: x = -int'($urandom_range(0, 40));
                default: x = $urandom_range(0, 255);
            endcase
            if (run_kind == 1 || run_kind == 2) begin
                prev_y = prev_y + AXIS_W'(int'($urandom_range(0, 6)) - 3);
                prev_z = prev_z + AXIS_W'(int'($urandom_range(0, 6)) - 3);
            end else begin
                prev_y = AXIS_W'($urandom);
                prev_z = AXIS_W'($urandom);
            end
            case ($urandom_range(0, 9))
                6, 7, 8: ms = $urandom_range(0, 2000);
                9:       ms = $urandom_range(0, 65535);
                default: ms = $urandom_range(0, 50);
            endcase
            push_sample(x, int'(prev_y), int'(prev_z), ms);
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset values: first sample against a zero previous magnitude,
        // saturation both ways and the low-speed cutoff.
        push_sample(-128, -128, -128, 0);
        push_sample(0, 0, 0, 0);
        push_sample(127, 127, 127, 65535);
        push_sample(-128, 0, 0, 65535);
        push_sample(1, 0, 0, 1);
        push_sample(1, 0, 0, 200);
        push_sample(-1, 0, 0, 100);
        push_sample(127, -128, 127, 0);
        wait_idle();

        // Writes to indexes past the last register must change nothing.
        write_reg(CFG_IDX_W'(int'(CFG_SPEED_ALARM_LEVEL) + $urandom_range(1, 251)), $urandom);
        write_reg('1, '1);

        // A change of exactly the threshold is not flagged; one above it is.
        write_all_regs(8'd1, 16'hFFFF, '0, '0);
        push_sample(0, 0, 0, 0);
        push_sample(1, 0, 0, 1);
        push_sample(3, 0, 0, 1);
        push_sample(3, 0, 0, 0);
        push_sample(-128, -128, -128, 65535);
        push_sample(127, 127, 127, 65535);
        wait_idle();

        // A saturated speed is not below the largest cutoff and never over
        // the largest alarm level.
        write_all_regs(8'hFF, 16'hFFFF, '1, '1);
        push_sample(127, 127, 127, 65535);
        push_sample(-128, -128, -128, 0);
        push_sample(0, 0, 0, 1);
        push_sample(-1, 0, 0, 1);
        wait_idle();

        write_all_regs(8'd0, 16'd0, '0, '0);
        push_sample(5, 5, 5, 100);
        push_sample(5, 5, 5, 100);
        push_sample(-5, 5, 6, 100);
        wait_idle();

        for (int p = 0; p < 6; p++) begin
            write_all_regs(THR_W'($urandom_range(0, 255)),
                           (p % 2 == 1) ? GAIN_W'($urandom_range(0, 65535))
                                        : GAIN_W'($urandom_range(1, 20000)),
                           SPEED_W'($urandom_range(0, 1 << 25)),
                           (p == 3) ? SPEED_W'($urandom) : SPEED_W'($urandom_range(0, 1 << 30)));
            push_random(125);
            wait_idle();
        end

        quiet_run = 1'b1;
        write_all_regs(RST_JERK_THRESHOLD, RST_SPEED_GAIN, RST_LOW_SPEED_CUTOFF,
                       RST_SPEED_ALARM_LEVEL);
        push_random(80);
        wait_idle();

        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
